// ===== sv/divrem_pkg.sv =====
// Shared constants and types for the 64-bit integer divider.
`default_nettype none

package divrem_pkg;

  // Operand width that the divider works on; port fields stay at PORT_WIDTH.
  localparam int DATA_WIDTH = 64;
  localparam int PORT_WIDTH = 64;

  // Signed operation select on the opcode field.
  localparam logic OP_UNSIGNED = 1'b0;
  localparam logic OP_SIGNED   = 1'b1;

  // One item in flight through the row of division cells.
  typedef struct packed {
    logic                  valid;
    logic                  neg_q;  // negate quotient at the end
    logic                  neg_r;  // negate remainder at the end
    logic [DATA_WIDTH-1:0] nq;     // dividend bits shift out on top, quotient bits in at bottom
    logic [DATA_WIDTH-1:0] rem;    // partial remainder
    logic [DATA_WIDTH-1:0] den;    // absolute divisor
  } stage_t;

  // Finished result waiting for the consumer.
  typedef struct packed {
    logic [DATA_WIDTH-1:0] quo;
    logic [DATA_WIDTH-1:0] rem;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/divrem_cell.sv =====
// One restoring division step with its output register.
`default_nettype none

module divrem_cell
  import divrem_pkg::*;
(
  input  wire    clk,
  input  wire    rst,
  input  wire    en,
  input  stage_t prev,
  output stage_t curr
);

  logic                  carry;
  logic                  ge;
  logic [DATA_WIDTH-1:0] shifted;
  logic [DATA_WIDTH-1:0] rem_next;
  logic [DATA_WIDTH-1:0] nq_next;

  // Shift the next dividend bit in; the bit shifted out counts in the compare.
  always_comb begin
    carry    = prev.rem[DATA_WIDTH-1];
    shifted  = {prev.rem[DATA_WIDTH-2:0], prev.nq[DATA_WIDTH-1]};
    ge       = carry || (shifted >= prev.den);
    rem_next = ge ? (shifted - prev.den) : shifted;
    nq_next  = {prev.nq[DATA_WIDTH-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      curr.valid <= 1'b0;
    end else if (en) begin
      curr.valid <= prev.valid;
    end
    if (en) begin
      curr.neg_q <= prev.neg_q;
      curr.neg_r <= prev.neg_r;
      curr.nq    <= nq_next;
      curr.rem   <= rem_next;
      curr.den   <= prev.den;
    end
  end

endmodule

`default_nettype wire

// ===== sv/divrem_outq.sv =====
// Two-entry result queue in front of the output port.
`default_nettype none

module divrem_outq
  import divrem_pkg::*;
(
  input  wire     clk,
  input  wire     rst,
  input  wire     push,
  input  result_t push_data,
  input  wire     pop,
  output logic    full,
  output logic    head_valid,
  output result_t head
);

  result_t    entry [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("result queue count out of range");
  assert property (@(posedge clk) disable iff (rst) full |-> !push || pop)
    else $error("push into full result queue");
  assert property (@(posedge clk) disable iff (rst) (count == 2'd0) |-> !pop)
    else $error("pop from empty result queue");
`endif

endmodule

`default_nettype wire

// ===== sv/int64_divide_remainder.sv =====
// Top level of the pipelined 64-bit signed/unsigned divider with remainder.
`default_nettype none

// Fully pipelined restoring divider. An item is taken every cycle while the
// row is not stalled; its result passes through one input register that
// takes absolute values, one division cell per quotient bit, and a
// two-entry result queue after the sign fix-up. Throughput is one item
// per cycle as long as the consumer keeps up; when it stalls, bubbles in the
// cell row still drain into the queue and the input keeps accepting until a
// result would find the queue full. Division by zero returns an all-ones
// magnitude quotient and the dividend as remainder, with the usual sign rules;
// the most negative value divided by minus one wraps to itself.
module int64_divide_remainder
  import divrem_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire                   opcode,
  input  wire  [PORT_WIDTH-1:0] dividend,
  input  wire  [PORT_WIDTH-1:0] divisor,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [PORT_WIDTH-1:0] quotient,
  output logic [PORT_WIDTH-1:0] remainder
);

  stage_t                stg [0:DATA_WIDTH];
  logic                  en;
  logic                  q_full;
  logic                  q_push;
  logic                  q_pop;
  result_t               q_in;
  result_t               q_head;
  logic [DATA_WIDTH-1:0] a;
  logic [DATA_WIDTH-1:0] b;
  logic                  a_neg;
  logic                  b_neg;
  logic [DATA_WIDTH-1:0] a_abs;
  logic [DATA_WIDTH-1:0] b_abs;

  // Stall the row only when a finished result would find the queue full.
  assign en       = !(q_full && !out_ready && stg[DATA_WIDTH].valid);
  assign in_ready = en;

  always_comb begin
    a     = dividend[DATA_WIDTH-1:0];
    b     = divisor[DATA_WIDTH-1:0];
    a_neg = (opcode == OP_SIGNED) && a[DATA_WIDTH-1];
    b_neg = (opcode == OP_SIGNED) && b[DATA_WIDTH-1];
    a_abs = a_neg ? (~a + 1'b1) : a;
    b_abs = b_neg ? (~b + 1'b1) : b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg[0].valid <= 1'b0;
    end else if (en) begin
      stg[0].valid <= in_valid;
    end
    if (en) begin
      stg[0].neg_q <= a_neg ^ b_neg;
      stg[0].neg_r <= a_neg;
      stg[0].nq    <= a_abs;
      stg[0].rem   <= '0;
      stg[0].den   <= b_abs;
    end
  end

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    divrem_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .prev (stg[i]),
      .curr (stg[i+1])
    );
  end

  // Apply the signs on the way into the queue.
  always_comb begin
    q_in.quo = stg[DATA_WIDTH].neg_q ? (~stg[DATA_WIDTH].nq + 1'b1) : stg[DATA_WIDTH].nq;
    q_in.rem = stg[DATA_WIDTH].neg_r ? (~stg[DATA_WIDTH].rem + 1'b1) : stg[DATA_WIDTH].rem;
  end

  assign q_push = stg[DATA_WIDTH].valid && en;
  assign q_pop  = out_valid && out_ready;

  divrem_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_in),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (out_valid),
    .head       (q_head)
  );

  assign quotient  = PORT_WIDTH'(q_head.quo);
  assign remainder = PORT_WIDTH'(q_head.rem);

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |=> stg[0].valid)
    else $error("accepted item missing from first stage");
  assert property (@(posedge clk) disable iff (rst)
                   !en |=> $stable(stg[DATA_WIDTH].valid) && $stable(stg[DATA_WIDTH].nq))
    else $error("last cell changed while row stalled");
  assert property (@(posedge clk) disable iff (rst) (stg[DATA_WIDTH].valid && !en) |-> out_valid)
    else $error("row stalled with empty result queue");
`endif

endmodule

`default_nettype wire
